// File: hw/rtl/bacc_pkg.sv
// bacc_pkg: types, constants and digit functions of the packed-decimal unit
// used by bacc_if, bacc_step and bcd_add_compare_convert; depends on nothing
package bacc_pkg;

    localparam int MAX_DIGITS      = 16;
    localparam int WORD_W          = 4 * MAX_DIGITS;
    localparam int BIN_W           = 31;
    localparam int BIN_DIGITS      = 10;
    localparam int BCD_W           = 4 * BIN_DIGITS;
    localparam int CONV_W          = BCD_W + BIN_W;
    localparam int STEPS           = 4;
    localparam int SHIFTS_PER_STEP = 8;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_CMP  = 2'd1,
        OP_CONV = 2'd2
    } op_e;

    typedef struct packed {
        logic [1:0]        op;
        logic [WORD_W-1:0] a_digits;
        logic [WORD_W-1:0] b_digits;
        logic [BIN_W-1:0]  bin_value;
    } in_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] res_digits;
        logic              overflow;
        logic              is_less;
        logic              is_equal;
        logic              is_greater;
    } out_beat_t;

    // control word carried down the pipeline
    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        carry;
        logic              lt;
        logic              gt;
        logic [CONV_W-1:0] conv;
    } ctl_t;

    typedef struct packed {
        logic [3:0] digit;
        logic [1:0] carry;
    } digit_res_t;

    // one decimal digit position, carry may reach 3 with non-decimal nibbles
    function automatic digit_res_t add_digit(input logic [3:0] x, input logic [3:0] y,
                                             input logic [1:0] c);
        logic [5:0] s;
        digit_res_t r;
        s = 6'(x) + 6'(y) + 6'(c);
        if (s >= 6'd30)
        begin
            r.carry = 2'd3;
            r.digit = 4'(s - 6'd30);
        end
        else if (s >= 6'd20)
        begin
            r.carry = 2'd2;
            r.digit = 4'(s - 6'd20);
        end
        else if (s >= 6'd10)
        begin
            r.carry = 2'd1;
            r.digit = 4'(s - 6'd10);
        end
        else
        begin
            r.carry = 2'd0;
            r.digit = 4'(s);
        end
        return r;
    endfunction

    // one shift-and-add-3 step, bcd digits above the binary bits
    function automatic logic [CONV_W-1:0] dabble(input logic [CONV_W-1:0] v);
        logic [CONV_W-1:0] t;
        t = v;
        for (int i = 0; i < BIN_DIGITS; i++)
        begin
            if (t[BIN_W+4*i +: 4] >= 4'd5)
            begin
                t[BIN_W+4*i +: 4] = t[BIN_W+4*i +: 4] + 4'd3;
            end
        end
        return {t[CONV_W-2:0], 1'b0};
    endfunction

endpackage

// File: hw/rtl/bacc_if.sv
// bacc_in_if, bacc_out_if: valid/ready channels of the packed-decimal unit
// payload types come from bacc_pkg
interface bacc_in_if;
    logic               valid;
    logic               ready;
    bacc_pkg::in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bacc_out_if;
    logic                valid;
    logic                ready;
    bacc_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/bacc_step.sv
// bacc_step: one pipeline step, a slice of the decimal add, up to eight
// conversion shifts and, in the first step, the digit compare; uses bacc_pkg
module bacc_step #(
    parameter int NUM_DIGITS = 16,
    parameter int STEP       = 0
) (
    input  bacc_pkg::ctl_t          ctl_in,
    input  logic [4*NUM_DIGITS-1:0] a,
    input  logic [4*NUM_DIGITS-1:0] b,
    input  logic [4*NUM_DIGITS-1:0] sum_in,
    output bacc_pkg::ctl_t          ctl_out,
    output logic [4*NUM_DIGITS-1:0] sum_out
);
    import bacc_pkg::*;

    localparam int DPS = (NUM_DIGITS + STEPS - 1) / STEPS;

    logic [1:0] carry [DPS+1];

    assign carry[0] = ctl_in.carry;

    for (genvar d = 0; d < NUM_DIGITS; d++)
    begin : g_digit
        localparam int T = d - STEP * DPS;
        if (T >= 0 && T < DPS)
        begin : g_add
            digit_res_t r;
            assign r = add_digit(a[4*d +: 4], b[4*d +: 4], carry[T]);
            assign sum_out[4*d +: 4] = r.digit;
            assign carry[T+1] = r.carry;
        end
        else
        begin : g_pass
            assign sum_out[4*d +: 4] = sum_in[4*d +: 4];
        end
    end

    // slots past the top digit pass the carry on
    for (genvar t = 0; t < DPS; t++)
    begin : g_slot
        if (STEP * DPS + t >= NUM_DIGITS)
        begin : g_idle
            assign carry[t+1] = carry[t];
        end
    end

    always_comb
    begin
        ctl_out = ctl_in;
        ctl_out.carry = carry[DPS];
        for (int t = 0; t < SHIFTS_PER_STEP; t++)
        begin
            if (STEP * SHIFTS_PER_STEP + t < BIN_W)
            begin
                ctl_out.conv = dabble(ctl_out.conv);
            end
        end
        if (STEP == 0)
        begin
            // higher digits override lower ones
            ctl_out.lt = 1'b0;
            ctl_out.gt = 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (a[4*i +: 4] < b[4*i +: 4])
                begin
                    ctl_out.lt = 1'b1;
                    ctl_out.gt = 1'b0;
                end
                else if (a[4*i +: 4] > b[4*i +: 4])
                begin
                    ctl_out.lt = 1'b0;
                    ctl_out.gt = 1'b1;
                end
            end
        end
    end

endmodule

// File: hw/rtl/bcd_add_compare_convert.sv
// bcd_add_compare_convert: packed-decimal add, compare and binary conversion
// a beat is registered at each step and then in out_reg; depth set by the
// 31 conversion shifts, at most eight per step; one beat per cycle unless rsp stalls
// reset: clears the stage valid flags only, payload registers are not reset
// depends on bacc_pkg, bacc_if and bacc_step
module bcd_add_compare_convert #(
    parameter int NUM_DIGITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    bacc_in_if.sink           req,
    bacc_out_if.source        rsp
);
    import bacc_pkg::*;

    localparam int ND = (NUM_DIGITS > MAX_DIGITS) ? MAX_DIGITS : NUM_DIGITS;
    localparam int NW = 4 * ND;

    logic [STEPS:0]  valid_reg;
    logic [STEPS:0]  valid_next;
    logic [STEPS:0]  rdy;

    ctl_t            ctl_reg [STEPS];
    logic [NW-1:0]   a_reg   [STEPS];
    logic [NW-1:0]   b_reg   [STEPS];
    logic [NW-1:0]   sum_reg [STEPS];

    ctl_t            ctl_step [STEPS];
    logic [NW-1:0]   sum_step [STEPS];

    out_beat_t       out_reg;
    out_beat_t       out_next;

    // stage k may load when empty or when its contents move on
    always_comb
    begin
        rdy[STEPS] = !valid_reg[STEPS] || rsp.ready;
        for (int k = STEPS - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next = valid_reg;
        if (rdy[0])
        begin
            valid_next[0] = req.valid;
        end
        for (int k = 1; k <= STEPS; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    assign req.ready = rdy[0];
    assign rsp.valid = valid_reg[STEPS];
    assign rsp.data  = out_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        bacc_step #(
            .NUM_DIGITS (ND),
            .STEP       (k)
        ) u_step (
            .ctl_in  (ctl_reg[k]),
            .a       (a_reg[k]),
            .b       (b_reg[k]),
            .sum_in  (sum_reg[k]),
            .ctl_out (ctl_step[k]),
            .sum_out (sum_step[k])
        );
    end

    always_comb
    begin
        ctl_t c;
        c = ctl_step[STEPS-1];
        out_next = '0;
        unique case (c.op)
            OP_ADD:
            begin
                out_next.res_digits = WORD_W'(sum_step[STEPS-1]);
                out_next.overflow   = (c.carry != 2'd0);
            end
            OP_CMP:
            begin
                out_next.is_less    = c.lt;
                out_next.is_greater = c.gt;
                out_next.is_equal   = !c.lt && !c.gt;
            end
            OP_CONV:
            begin
                out_next.res_digits = WORD_W'(c.conv[CONV_W-1:BIN_W]);
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ctl_reg[0] <= '{op:    req.data.op,
                            carry: 2'd0,
                            lt:    1'b0,
                            gt:    1'b0,
                            conv:  {{BCD_W{1'b0}}, req.data.bin_value}};
            a_reg[0]   <= req.data.a_digits[NW-1:0];
            b_reg[0]   <= req.data.b_digits[NW-1:0];
            sum_reg[0] <= '0;
        end
        for (int k = 1; k < STEPS; k++)
        begin
            if (rdy[k])
            begin
                ctl_reg[k] <= ctl_step[k-1];
                a_reg[k]   <= a_reg[k-1];
                b_reg[k]   <= b_reg[k-1];
                sum_reg[k] <= sum_step[k-1];
            end
        end
        if (rdy[STEPS])
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_flags_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> $onehot0({rsp.data.is_less, rsp.data.is_equal, rsp.data.is_greater}))
        else $error("more than one compare flag set");

    a_flags_only_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.data.res_digits != '0 || rsp.data.overflow))
        |-> !(rsp.data.is_less || rsp.data.is_equal || rsp.data.is_greater))
        else $error("compare flags on a non-compare beat");

    a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg[STEPS]) |-> $past(valid_reg[STEPS-1]))
        else $error("result valid without a beat in the last stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STEPS-1] && !rdy[STEPS]) |=> valid_reg[STEPS-1])
        else $error("beat lost in last stage while output stalled");
`endif

endmodule
